// ===== hw/rtl/heading_pid_rotation_controller_unit_macros.svh =====
// assertion macros shared by the checker files of the heading controller
// no dependencies; included by the checker only
`ifndef HEADING_PID_ROTATION_CONTROLLER_UNIT_MACROS_SVH
`define HEADING_PID_ROTATION_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define HPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define HPRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define HPRC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hprc_pkg.sv =====
// shared types, constants and angle helpers of the heading controller
// no dependencies
`timescale 1ns / 1ps

package hprc_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int ANG_W        = 15;   // input angle fields
  localparam int EXT_W        = 17;   // sums of two angles
  localparam int HEAD_W       = 16;   // wrapped heading
  localparam int ERR_W        = 16;   // wrapped error
  localparam int DER_W        = 17;   // error difference
  localparam int GAIN_W       = 16;
  localparam int THR_W        = 14;
  localparam int SPEED_W      = 24;
  localparam int SUM_WIDTH_DEF = 32;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 40;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  // integral operand is clamped to this width; beyond it the speed saturates anyway
  localparam int ISAT_W  = SPEED_W + FRAC_BITS + 1;
  localparam int IHI_W   = 17;
  localparam int ILO_W   = ISAT_W - IHI_W;
  localparam int TOT_W   = ISAT_W + GAIN_W + 2;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam int PI_INT =
    int'((PI_Q30 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam logic signed [EXT_W-1:0] PI_Q     = EXT_W'(PI_INT);
  localparam logic signed [EXT_W-1:0] TWO_PI_Q = EXT_W'(2 * PI_INT);

  localparam logic [GAIN_W-1:0] KP_RESET  = GAIN_W'(2 ** (FRAC_BITS - 1));
  localparam logic [GAIN_W-1:0] KI_RESET  = '0;
  localparam logic [GAIN_W-1:0] KD_RESET  = '0;
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'((2 ** FRAC_BITS) / 5);

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_YAW     = 1'b1;

  localparam logic [1:0] REG_KP  = 2'd0;
  localparam logic [1:0] REG_KI  = 2'd1;
  localparam logic [1:0] REG_KD  = 2'd2;
  localparam logic [1:0] REG_THR = 2'd3;

  typedef struct packed {
    logic                     cmd_pending;
    logic signed [ANG_W-1:0]  pend_angle;
    logic                     rotating;
    logic signed [HEAD_W-1:0] target;
    logic signed [ANG_W-1:0]  start;
    logic signed [EXT_W-1:0]  last_err;
  } ctl_state_t;

  typedef struct packed {
    logic                    valid;
    logic                    finished;
    logic signed [ERR_W-1:0] err;
    logic signed [DER_W-1:0] deriv;
    logic signed [ANG_W-1:0] turned;
  } step_res_t;

  // one step of wrapping into +-pi
  function automatic logic signed [EXT_W-1:0] wrap_angle(input logic signed [EXT_W-1:0] a);
    logic signed [EXT_W-1:0] w;
    w = a;
    if (w > PI_Q) begin
      w = w - TWO_PI_Q;
    end
    if (w < -PI_Q) begin
      w = w + TWO_PI_Q;
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/hprc_step.sv =====
// per-word control step: pending command, target capture, error and integral update
// depends on hprc_pkg
`timescale 1ns / 1ps

module hprc_step #(
  parameter int SUM_WIDTH = hprc_pkg::SUM_WIDTH_DEF
) (
  input  logic                              op,
  input  logic signed [hprc_pkg::ANG_W-1:0] cmd_angle,
  input  logic signed [hprc_pkg::ANG_W-1:0] yaw,
  input  logic [hprc_pkg::THR_W-1:0]        thr,
  input  hprc_pkg::ctl_state_t              st,
  input  logic signed [SUM_WIDTH-1:0]       sum,
  output hprc_pkg::ctl_state_t              st_nxt,
  output logic signed [SUM_WIDTH-1:0]       sum_nxt,
  output hprc_pkg::step_res_t               res
);

  logic signed [hprc_pkg::EXT_W-1:0] tgt_raw;
  logic signed [hprc_pkg::EXT_W-1:0] err_ext;
  logic signed [hprc_pkg::EXT_W-1:0] turn_ext;
  logic signed [hprc_pkg::ERR_W-1:0] err;
  logic [hprc_pkg::ERR_W-1:0]        mag;
  logic signed [hprc_pkg::EXT_W:0]   der_ext;
  logic signed [SUM_WIDTH:0]         sum_w;
  hprc_pkg::ctl_state_t              cur;

  always_comb begin
    st_nxt   = st;
    sum_nxt  = sum;
    res      = '0;
    cur      = st;
    tgt_raw  = hprc_pkg::EXT_W'(st.pend_angle) + hprc_pkg::EXT_W'(yaw);
    err_ext  = '0;
    err      = '0;
    mag      = '0;
    der_ext  = '0;
    sum_w    = '0;
    turn_ext = '0;
    if (op == hprc_pkg::OP_COMMAND) begin
      st_nxt.cmd_pending = 1'b1;
      st_nxt.pend_angle  = cmd_angle;
    end else begin
      // a pending command starts or retargets the rotation on this sample
      if (st.cmd_pending) begin
        cur.cmd_pending = 1'b0;
        cur.start       = yaw;
        cur.last_err    = tgt_raw;
        cur.target      = hprc_pkg::HEAD_W'(hprc_pkg::wrap_angle(tgt_raw));
        cur.rotating    = 1'b1;
      end
      if (cur.rotating) begin
        err_ext = hprc_pkg::wrap_angle(hprc_pkg::EXT_W'(cur.target) - hprc_pkg::EXT_W'(yaw));
        err     = hprc_pkg::ERR_W'(err_ext);
        mag     = err[hprc_pkg::ERR_W-1] ? hprc_pkg::ERR_W'(-err) : hprc_pkg::ERR_W'(err);
        res.valid = 1'b1;
        if (mag > hprc_pkg::ERR_W'(thr)) begin
          der_ext = (hprc_pkg::EXT_W+1)'(err) - (hprc_pkg::EXT_W+1)'(cur.last_err);
          sum_w   = (SUM_WIDTH+1)'(sum) + (SUM_WIDTH+1)'(err);
          if (sum_w[SUM_WIDTH] != sum_w[SUM_WIDTH-1]) begin
            sum_nxt = sum_w[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
          end else begin
            sum_nxt = sum_w[SUM_WIDTH-1:0];
          end
          cur.last_err = hprc_pkg::EXT_W'(err);
          res.err      = err;
          res.deriv    = hprc_pkg::DER_W'(der_ext);
        end else begin
          turn_ext     = hprc_pkg::wrap_angle(hprc_pkg::EXT_W'(yaw) - hprc_pkg::EXT_W'(cur.start));
          cur.rotating = 1'b0;
          res.finished = 1'b1;
          res.turned   = hprc_pkg::ANG_W'(turn_ext);
        end
      end
      st_nxt = cur;
    end
  end

endmodule

// ===== hw/rtl/heading_pid_rotation_controller_unit.sv =====
// Heading PID rotation controller.
// in_*: one word per command or yaw sample; in_tuser is the operation
// (0 = rotation command, 1 = yaw sample), in_tdata holds command angle and yaw.
// out_*: one word per yaw sample taken while rotating; out_tuser is finished,
// out_tdata holds the speed and, on the finishing sample, the angle turned.
// Commands and yaw samples with nothing to rotate give no output word.
// cfg_*: APB-style registers at 0x0 kp, 0x4 ki, 0x8 kd, 0xC done threshold;
// write them only while the block is idle.
// After the input register, a word passes the control step, the multipliers and the final
// sum and rounding, each ending in a register.
// Throughput: one word per cycle unless out_tready stalls; the control state recurrence
// closes in the single control-step stage, the products follow in their own stages.
// Reset (synchronous, rst_n low) clears the rotation state, the integral and
// all pipeline words, and loads the default gains and threshold.
// When out_tready is low, words collect in the pipeline bubbles; in_tready
// drops once the input register, both internal stages and the output hold words.
// depends on hprc_pkg and hprc_step
`timescale 1ns / 1ps

module heading_pid_rotation_controller_unit #(
  parameter int SUM_WIDTH = hprc_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hprc_pkg::IN_DATA_W-1:0]      in_tdata,   // command_angle[14:0], yaw[29:15]
  input  logic                                in_tuser,   // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [hprc_pkg::OUT_DATA_W-1:0]     out_tdata,  // speed[23:0], turned_angle[38:24]
  output logic                                out_tuser,  // finished
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hprc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [hprc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [hprc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int XW = (SUM_WIDTH > hprc_pkg::ISAT_W) ? SUM_WIDTH : hprc_pkg::ISAT_W;
  localparam logic signed [XW-1:0] IMAX_X =
    XW'((longint'(1) <<< (hprc_pkg::ISAT_W - 1)) - 1);
  localparam logic signed [XW-1:0] IMIN_X = -IMAX_X;
  localparam logic signed [hprc_pkg::TOT_W-1:0] RND =
    hprc_pkg::TOT_W'(longint'(1) <<< (hprc_pkg::FRAC_BITS - 1));
  localparam logic signed [hprc_pkg::TOT_W-1:0] SPD_MAX =
    hprc_pkg::TOT_W'((longint'(1) <<< (hprc_pkg::SPEED_W - 1)) - 1);
  localparam logic signed [hprc_pkg::TOT_W-1:0] SPD_MIN =
    -hprc_pkg::TOT_W'(longint'(1) <<< (hprc_pkg::SPEED_W - 1));

  // configuration registers
  logic [hprc_pkg::GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [hprc_pkg::THR_W-1:0]  thr_r;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[hprc_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= hprc_pkg::KP_RESET;
      ki_r  <= hprc_pkg::KI_RESET;
      kd_r  <= hprc_pkg::KD_RESET;
      thr_r <= hprc_pkg::THR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hprc_pkg::REG_KP:  kp_r  <= cfg_pwdata[hprc_pkg::GAIN_W-1:0];
        hprc_pkg::REG_KI:  ki_r  <= cfg_pwdata[hprc_pkg::GAIN_W-1:0];
        hprc_pkg::REG_KD:  kd_r  <= cfg_pwdata[hprc_pkg::GAIN_W-1:0];
        hprc_pkg::REG_THR: thr_r <= cfg_pwdata[hprc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hprc_pkg::REG_KP:  cfg_prdata = hprc_pkg::CFG_DATA_W'(kp_r);
      hprc_pkg::REG_KI:  cfg_prdata = hprc_pkg::CFG_DATA_W'(ki_r);
      hprc_pkg::REG_KD:  cfg_prdata = hprc_pkg::CFG_DATA_W'(kd_r);
      hprc_pkg::REG_THR: cfg_prdata = hprc_pkg::CFG_DATA_W'(thr_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // pipeline flow: each stage loads when empty or when its word moves on
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic rdy1, rdy2, rdy3, fire0;

  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign fire0     = v0_r && rdy1;
  assign in_tready = !v0_r || rdy1;

  // input register
  logic                              op0_r;
  logic signed [hprc_pkg::ANG_W-1:0] cmd0_r, yaw0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op0_r  <= in_tuser;
      cmd0_r <= in_tdata[hprc_pkg::ANG_W-1:0];
      yaw0_r <= in_tdata[2*hprc_pkg::ANG_W-1:hprc_pkg::ANG_W];
    end
  end

  // control step and its state
  hprc_pkg::ctl_state_t        st_r, st_nxt;
  logic signed [SUM_WIDTH-1:0] sum_r, sum_nxt;
  hprc_pkg::step_res_t         res;

  hprc_step #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_step (
    .op        (op0_r),
    .cmd_angle (cmd0_r),
    .yaw       (yaw0_r),
    .thr       (thr_r),
    .st        (st_r),
    .sum       (sum_r),
    .st_nxt    (st_nxt),
    .sum_nxt   (sum_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      sum_r <= '0;
    end else if (fire0) begin
      st_r  <= st_nxt;
      sum_r <= sum_nxt;
    end
  end

  // stage 1: error terms and integral
  logic                              fin1_r;
  logic signed [hprc_pkg::ERR_W-1:0] err1_r;
  logic signed [hprc_pkg::DER_W-1:0] der1_r;
  logic signed [hprc_pkg::ANG_W-1:0] trn1_r;
  logic signed [SUM_WIDTH-1:0]       sum1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= fire0 && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      fin1_r <= res.finished;
      err1_r <= res.err;
      der1_r <= res.deriv;
      trn1_r <= res.turned;
      sum1_r <= sum_nxt;
    end
  end

  // integral clamp then products
  logic signed [XW-1:0]                              sum_x, sum_xc;
  logic signed [hprc_pkg::ISAT_W-1:0]                sum_c;
  logic signed [hprc_pkg::GAIN_W+hprc_pkg::ERR_W:0]  pp_nxt;
  logic signed [hprc_pkg::GAIN_W+hprc_pkg::DER_W:0]  pd_nxt;
  logic [hprc_pkg::GAIN_W+hprc_pkg::ILO_W-1:0]       pil_nxt;
  logic signed [hprc_pkg::GAIN_W+hprc_pkg::IHI_W:0]  pih_nxt;

  always_comb begin
    sum_x = XW'(sum1_r);
    if (sum_x > IMAX_X) begin
      sum_xc = IMAX_X;
    end else if (sum_x < IMIN_X) begin
      sum_xc = IMIN_X;
    end else begin
      sum_xc = sum_x;
    end
    sum_c = hprc_pkg::ISAT_W'(sum_xc);
  end

  assign pp_nxt  = $signed({1'b0, kp_r}) * err1_r;
  assign pd_nxt  = $signed({1'b0, kd_r}) * der1_r;
  assign pil_nxt = ki_r * sum_c[hprc_pkg::ILO_W-1:0];
  assign pih_nxt = $signed({1'b0, ki_r}) * $signed(sum_c[hprc_pkg::ISAT_W-1:hprc_pkg::ILO_W]);

  // stage 2: products
  logic                                              fin2_r;
  logic signed [hprc_pkg::ANG_W-1:0]                 trn2_r;
  logic signed [hprc_pkg::GAIN_W+hprc_pkg::ERR_W:0]  pp2_r;
  logic signed [hprc_pkg::GAIN_W+hprc_pkg::DER_W:0]  pd2_r;
  logic [hprc_pkg::GAIN_W+hprc_pkg::ILO_W-1:0]       pil2_r;
  logic signed [hprc_pkg::GAIN_W+hprc_pkg::IHI_W:0]  pih2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      fin2_r <= fin1_r;
      trn2_r <= trn1_r;
      pp2_r  <= pp_nxt;
      pd2_r  <= pd_nxt;
      pil2_r <= pil_nxt;
      pih2_r <= pih_nxt;
    end
  end

  // final sum, round half up, saturate; zero speed on a finishing word
  logic signed [hprc_pkg::TOT_W-1:0]   total, quo;
  logic signed [hprc_pkg::SPEED_W-1:0] speed_nxt;

  always_comb begin
    total = hprc_pkg::TOT_W'(pp2_r) + hprc_pkg::TOT_W'(pd2_r)
          + (hprc_pkg::TOT_W'(pih2_r) <<< hprc_pkg::ILO_W)
          + hprc_pkg::TOT_W'($signed({1'b0, pil2_r})) + RND;
    quo = total >>> hprc_pkg::FRAC_BITS;
    if (fin2_r) begin
      speed_nxt = '0;
    end else if (quo > SPD_MAX) begin
      speed_nxt = hprc_pkg::SPEED_W'(SPD_MAX);
    end else if (quo < SPD_MIN) begin
      speed_nxt = hprc_pkg::SPEED_W'(SPD_MIN);
    end else begin
      speed_nxt = hprc_pkg::SPEED_W'(quo);
    end
  end

  // output register
  logic                                out_fin_r;
  logic signed [hprc_pkg::SPEED_W-1:0] out_speed_r;
  logic signed [hprc_pkg::ANG_W-1:0]   out_turn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_fin_r   <= fin2_r;
      out_speed_r <= speed_nxt;
      out_turn_r  <= fin2_r ? trn2_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fin_r;
  assign out_tdata  = {{(hprc_pkg::OUT_DATA_W - hprc_pkg::SPEED_W - hprc_pkg::ANG_W){1'b0}},
                       out_turn_r, out_speed_r};

endmodule

// ===== hw/rtl/hprc_checker.sv =====
// port-level checks on the result channel of the heading controller
// depends on heading_pid_rotation_controller_unit_macros.svh and hprc_pkg; bound to the top level
`timescale 1ns / 1ps
`include "heading_pid_rotation_controller_unit_macros.svh"

module hprc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic                            out_tuser,
  input logic [hprc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled word holds
  `HPRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")

  // finishing word commands zero speed
  `HPRC_ASSERT_IMP(a_fin_zero_speed, clk, rst_n, out_tvalid && out_tuser, out_tdata[hprc_pkg::SPEED_W-1:0] == '0, "finished word with nonzero speed")

  // speed word carries no turned angle
  `HPRC_ASSERT_IMP(a_run_zero_turn, clk, rst_n, out_tvalid && !out_tuser, out_tdata[hprc_pkg::SPEED_W+hprc_pkg::ANG_W-1:hprc_pkg::SPEED_W] == '0, "turned angle set on speed word")

  // reset empties the output
  `HPRC_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind heading_pid_rotation_controller_unit hprc_checker u_hprc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
